FILE: design/ssk_pkg.sv
// Shared types, codes and helpers for the sorted unique key set.
// No dependencies; used by ssk_cell and sorted_unique_key_set.
`timescale 1ns / 1ps

package ssk_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_W         = 64;
  localparam int INDEX_W       = 5;
  localparam int COUNT_OUT_W   = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

  // Keep at most nbytes leading bytes and clear everything after the first zero byte.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw,
                                                 input int nbytes);
    logic [KEY_W-1:0] res;
    logic             stop;
    logic [7:0]       b;
    res  = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = raw[KEY_W-1-8*i -: 8];
      if (i >= nbytes || b == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[KEY_W-1-8*i -: 8] = b;
      end
    end
    return res;
  endfunction

endpackage

FILE: design/ssk_cell.sv
// One slot of the sorted key row: holds a key, compares it to the broadcast key
// and shifts toward either neighbor. Depends on ssk_pkg.
`timescale 1ns / 1ps

module ssk_cell (
  input  logic                   clk,
  input  ssk_pkg::cell_ctrl_t    ctrl,
  input  logic                   occupied,
  input  logic [ssk_pkg::KEY_W-1:0] k,
  input  logic [ssk_pkg::KEY_W-1:0] left_key,
  input  logic                   left_lt,
  input  logic [ssk_pkg::KEY_W-1:0] right_key,
  output logic [ssk_pkg::KEY_W-1:0] key,
  output logic                   lt,
  output logic                   eq
);
  import ssk_pkg::*;

  // Latch the compare against the broadcast key.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= occupied && (key < k);
      eq <= occupied && (key == k);
    end
  end

  // Cells at or above the sorted position move: right on insert, left on remove.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !lt) begin
      key <= left_lt ? k : left_key;
    end else if (ctrl.rem_en && !lt) begin
      key <= right_key;
    end
  end

endmodule

FILE: design/sorted_unique_key_set.sv
// Top level of the sorted unique key set: command port, control sequencer and
// the row of ssk_cell slots. Depends on ssk_pkg and ssk_cell.
`timescale 1ns / 1ps

// Channel   Direction  Transfer condition       Signals
// command   in         start & !busy at edge    op, key, index
// result    out        done (one cycle)         status, entry_count, key_out
//
// Each command passes through capture, where the key is trimmed, S_CMP, where
// every cell compares its key against it, and S_UPD, where the row shifts and
// the result is formed. The result strobe rises in the cycle after S_UPD, while
// busy is already low, so a new command can transfer alongside the strobe.
// Sync reset empties the set; stored keys are not cleared, only the count.
// The receiver cannot stall: done lasts exactly one cycle.

module sorted_unique_key_set #(
  parameter int CAPACITY  = ssk_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = ssk_pkg::KEY_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op,
  input  logic [ssk_pkg::KEY_W-1:0]    key,
  input  logic [ssk_pkg::INDEX_W-1:0]  index,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [ssk_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic [ssk_pkg::KEY_W-1:0]    key_out
);
  import ssk_pkg::*;

  localparam int CNTW = $clog2(CAPACITY + 1);

  state_t               state, state_next;
  logic [1:0]           op_q;
  logic [KEY_W-1:0]     key_q;
  logic [INDEX_W-1:0]   index_q;
  logic [CNTW-1:0]      count_q, count_next;
  cell_ctrl_t           ctrl;

  logic [KEY_W-1:0]     cell_key [CAPACITY];
  logic                 cell_lt  [CAPACITY];
  logic                 cell_eq  [CAPACITY];

  logic                 hit;
  logic                 full;
  logic                 idx_ok;
  logic [KEY_W-1:0]     rd_key;
  status_t              status_next;
  logic [KEY_W-1:0]     key_out_next;

  // Capture the command and trim the key once, on transfer.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q    <= op;
      key_q   <= norm_key(key, KEY_BYTES);
      index_q <= index;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Row of cells: each sees its neighbors; the head takes key_q as its left key.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] lkey;
    logic             llt;
    logic [KEY_W-1:0] rkey;
    if (i == 0) begin : g_head
      assign lkey = key_q;
      assign llt  = 1'b1;
    end else begin : g_body
      assign lkey = cell_key[i-1];
      assign llt  = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rkey = cell_key[i];
    end else begin : g_mid
      assign rkey = cell_key[i+1];
    end

    ssk_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (CNTW'(i) < count_q),
      .k         (key_q),
      .left_key  (lkey),
      .left_lt   (llt),
      .right_key (rkey),
      .key       (cell_key[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  // Hit and read data gathered across the row.
  always_comb begin
    hit    = 1'b0;
    rd_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit = hit | cell_eq[i];
      if (32'(index_q) == i) begin
        rd_key = rd_key | cell_key[i];
      end
    end
  end

  assign full   = (count_q == CNTW'(CAPACITY));
  assign idx_ok = (32'(index_q) < 32'(count_q)) && (32'(index_q) < CAPACITY);

  // Outputs of the sequencer: busy flag, cell control, result and next count.
  always_comb begin
    busy         = (state != S_IDLE);
    ctrl         = '0;
    count_next   = count_q;
    status_next  = ST_BAD_INDEX;
    key_out_next = '0;
    ctrl.cmp_en  = (state == S_CMP);
    if (state == S_UPD) begin
      case (op_q)
        OP_INSERT: begin
          if (hit) begin
            status_next = ST_DUPLICATE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_next  = count_q + 1'b1;
            status_next = ST_INSERTED;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            ctrl.rem_en = 1'b1;
            count_next  = count_q - 1'b1;
            status_next = ST_REMOVED;
          end else begin
            status_next = ST_NOT_FOUND;
          end
        end
        OP_READ: begin
          if (idx_ok) begin
            status_next  = ST_READ_OK;
            key_out_next = rd_key;
          end
        end
        default: status_next = ST_BAD_INDEX;
      endcase
    end
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
    end else begin
      count_q <= count_next;
    end
  end

  // Result strobe and payload; hold payload between results.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      status      <= status_next;
      entry_count <= COUNT_OUT_W'(count_next);
      key_out     <= key_out_next;
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNTW'(CAPACITY))
    else $error("count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_INSERTED |-> count_q == CNTW'($past(count_q) + 1'b1))
    else $error("insert did not grow the set by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_REMOVED |-> count_q == CNTW'($past(count_q) - 1'b1))
    else $error("remove did not shrink the set by one");

endmodule

FILE: tb/sv/tb_sorted_unique_key_set.sv
// Self-checking testbench for sorted_unique_key_set: directed and random command traffic,
// with every result checked against a shadow copy of the sorted key table.
// Depends on ssk_pkg and the sorted_unique_key_set RTL.
`timescale 1ns / 1ps

module tb_sorted_unique_key_set;
  import ssk_pkg::*;

  localparam int         SET_DEPTH      = CAPACITY_DEF;
  localparam logic [1:0] OP_UNUSED      = 2'd3;     // op code with no defined operation
  localparam int         DRAIN_CYCLES   = 8;        // idle time after the last result before the verdict
  localparam int         WATCHDOG_LIMIT = 2000;     // cycles with no transfer at all
  localparam int         POOL_SIZE      = 48;       // more keys than slots, so the table fills

  // One expected result, as the block reports it.
  typedef struct {
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
    logic [KEY_W-1:0]       key_out;
  } set_result_t;

  logic                   clk   = 1'b0;
  logic                   rst   = 1'b1;
  logic                   start = 1'b0;
  logic [1:0]             op    = OP_INSERT;
  logic [KEY_W-1:0]       key   = '0;
  logic [INDEX_W-1:0]     index = '0;
  logic                   busy;
  logic                   done;
  logic [2:0]             status;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic [KEY_W-1:0]       key_out;

  // Shadow of the block's state: ascending keys and how many are held.
  logic [KEY_W-1:0] shadow_keys [SET_DEPTH];
  int               shadow_count = 0;

  set_result_t      pending_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               fail_count      = 0;
  int               sender_idle_pct = 0;
  int               quiet_cycles    = 0;

  always #10 clk = ~clk;

  sorted_unique_key_set #(
    .CAPACITY  (SET_DEPTH),
    .KEY_BYTES (KEY_BYTES_DEF)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .key         (key),
    .index       (index),
    .done        (done),
    .status      (status),
    .entry_count (entry_count),
    .key_out     (key_out)
  );

  // Keys are text: drop everything from the first zero byte on.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    res = '0;
    for (int b = 0; b < KEY_BYTES_DEF; b++) begin
      if (raw[KEY_W-1-8*b -: 8] == 8'd0) break;
      res[KEY_W-1-8*b -: 8] = raw[KEY_W-1-8*b -: 8];
    end
    return res;
  endfunction

  // Apply one command to the shadow table and return the result it must produce.
  function automatic set_result_t apply_to_shadow_set(input logic [1:0]         cmd,
                                                      input logic [KEY_W-1:0]   raw_key,
                                                      input logic [INDEX_W-1:0] pos_req);
    set_result_t      r;
    logic [KEY_W-1:0] k;
    int               slot;
    bit               hit;
    k         = trim_key(raw_key);
    r.key_out = '0;
    // First slot whose key is not below k.
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < k) slot++;
    hit = (slot < shadow_count) && (shadow_keys[slot] == k);
    case (cmd)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_DUPLICATE;   // duplicate check wins over full
        end else if (shadow_count >= SET_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[slot] = k;
          shadow_count++;
          r.status = ST_INSERTED;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (int i = slot; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (pos_req < shadow_count) begin
          r.key_out = shadow_keys[pos_req];
          r.status  = ST_READ_OK;
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      default: begin
        r.status = ST_BAD_INDEX;   // unused op changes nothing
      end
    endcase
    r.count = COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Check the result strobe first, then log a new command transfer. Both live in one
  // block so the queue always sees the check before the new entry.
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no command outstanding: status %0d", status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count mismatch: expected %0d, actual %0d", want.count, entry_count);
          fail_count++;
        end
        if (key_out !== want.key_out) begin
          $error("key_out mismatch: expected %h, actual %h", want.key_out, key_out);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      pending_results.push_back(apply_to_shadow_set(op, key, index));
    end
  end

  // Stop a hung run: count cycles with neither a command transfer nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one command and hold it until the block takes it. Start stays high on
  // return, so back-to-back commands go out with no gap unless the sender idles.
  task automatic send_command(input logic [1:0]         cmd,
                              input logic [KEY_W-1:0]   k,
                              input logic [INDEX_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op    <= cmd;
    key   <= k;
    index <= pos;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);   // let the last transfer reach the queue
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random text key: 0..8 bytes, often from a tiny alphabet so prefixes are
  // shared; a shorter key ends in a zero byte, then zeros or garbage to be ignored.
  function automatic logic [KEY_W-1:0] random_text_key();
    logic [KEY_W-1:0] k;
    int               len;
    bit               junk_tail;
    k         = {$urandom, $urandom};
    len       = $urandom_range(0, 8);
    junk_tail = $urandom_range(0, 1);
    for (int b = 0; b < 8; b++) begin
      if (b < len) begin
        if ($urandom_range(0, 1)) k[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h61, 8'h64));
        else                      k[KEY_W-1-8*b -: 8] = 8'($urandom_range(1, 255));
      end else if (b == len || !junk_tail) begin
        k[KEY_W-1-8*b -: 8] = 8'd0;
      end
    end
    return k;
  endfunction

  task automatic test_empty_set();
    send_command(OP_READ,   '0, 5'd0);
    send_command(OP_READ,   '0, 5'd31);
    send_command(OP_REMOVE, '0, 5'd0);
    send_command(OP_REMOVE, 64'h6162_6300_0000_0000, 5'd0);
  endtask

  // Empty key, all-ones key, and keys whose bytes after a zero must be ignored.
  task automatic test_key_trimming();
    send_command(OP_INSERT, 64'h0000_0000_0000_0000, 5'd0);
    send_command(OP_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 5'd31);   // also empty: duplicate
    send_command(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_command(OP_INSERT, 64'h4100_4200_0000_0000, 5'd0);   // "A"
    send_command(OP_INSERT, 64'h4142_0043_4445_4647, 5'd0);   // "AB"
    send_command(OP_REMOVE, 64'h4100_FFFF_FFFF_FFFF, 5'd0);   // removes "A"
  endtask

  task automatic test_read_positions();
    send_command(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_command(OP_READ, '0, 5'd1);
    send_command(OP_READ, '0, 5'd2);
    send_command(OP_READ, '0, 5'd3);    // one past the end
    send_command(OP_READ, '0, 5'd31);
  endtask

  task automatic test_unused_op();
    send_command(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
  endtask

  task automatic test_remove_paths();
    send_command(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_command(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);   // now missing
    send_command(OP_REMOVE, 64'h0000_0000_0000_0000, 5'd0);
    wait_for_results();
  endtask

  // Insert in descending order so each key lands behind "AB" and the row behind it
  // shifts; run past capacity, hit a duplicate while full, then empty the table.
  task automatic test_capacity_limit();
    for (int i = 39; i >= 0; i--) send_command(OP_INSERT, {8'h6B, 8'(8'h41 + i), 48'h0}, '0);
    send_command(OP_INSERT, {8'h6B, 8'(8'h41 + 39), 48'h0}, '0);
    send_command(OP_READ, '0, 5'd31);
    send_command(OP_READ, '0, 5'd0);
    for (int i = 0; i < 40; i++) send_command(OP_REMOVE, {8'h6B, 8'(8'h41 + i), 48'h0}, '0);
    send_command(OP_REMOVE, 64'h4142_0000_0000_0000, '0);
    wait_for_results();
  endtask

  // Random traffic that sweeps the count between empty and full: fill mode leans
  // on inserts, drain mode on removes. Keys come mostly from a shared pool so that
  // duplicates and hits on remove are common.
  task automatic test_random_mix(input int n_items, input int idle_pct);
    bit                 filling;
    int                 pick;
    int                 hi;
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   k;
    logic [INDEX_W-1:0] pos;
    sender_idle_pct = idle_pct;
    filling         = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (shadow_count >= SET_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (filling) begin
        cmd = (pick < 60) ? OP_INSERT : (pick < 75) ? OP_REMOVE :
              (pick < 97) ? OP_READ : OP_UNUSED;
      end else begin
        cmd = (pick < 15) ? OP_INSERT : (pick < 60) ? OP_REMOVE :
              (pick < 97) ? OP_READ : OP_UNUSED;
      end
      pick = $urandom_range(0, 99);
      if (pick < 85)      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 95) k = random_text_key();
      else                k = {$urandom, $urandom};
      hi = (shadow_count < 31) ? shadow_count : 31;
      if ($urandom_range(0, 99) < 80) pos = INDEX_W'($urandom_range(0, hi));
      else                            pos = INDEX_W'($urandom_range(0, 31));
      send_command(cmd, k, pos);
      // Now and then hold the sender until the block has answered everything.
      if ($urandom_range(0, 59) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_text_key();

    test_empty_set();
    test_key_trimming();
    test_read_positions();
    test_unused_op();
    test_remove_paths();
    test_capacity_limit();
    test_random_mix(620, 16);
    test_random_mix(620, 53);
    test_random_mix(620, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
